// ===== hw/rtl/tunnel_header_parse_check_macros.svh =====
// assertion macros for the tunnel header parse and check block
`ifndef TUNNEL_HEADER_PARSE_CHECK_MACROS_SVH
`define TUNNEL_HEADER_PARSE_CHECK_MACROS_SVH
`ifndef NO_ASSERTIONS
`define THPC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define THPC_ASSERT_NEVER(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define THPC_ASSERT(name, prop, msg)
`define THPC_ASSERT_NEVER(name, prop, msg)
`endif
`endif

// ===== hw/rtl/thpc_pkg.sv =====
// types, codes and constants of the tunnel header parse and check block
package thpc_pkg;

  localparam int unsigned COUNT_BITS_DEF = 17;
  localparam int unsigned HDR_BYTES      = 28;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned CFG_IDX_W      = 3;

  localparam logic [31:0] MAGIC_WORD_RST     = 32'd0;
  localparam logic [7:0]  VERSION_RST        = 8'd1;
  localparam logic [15:0] MAX_INNER_LEN_RST  = 16'd1400;
  localparam logic [7:0]  TAG_LEN_RST        = 8'd16;
  localparam logic [15:0] CLIENT_HELLO_RST   = 16'd32;
  localparam logic [15:0] SERVER_HELLO_RST   = 16'd32;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_SHORT    = 4'd1,
    ST_MAGIC    = 4'd2,
    ST_VERSION  = 4'd3,
    ST_TYPE     = 4'd4,
    ST_HEADER   = 4'd5,
    ST_ZERO     = 4'd6,
    ST_OVERSIZE = 4'd7,
    ST_LEN      = 4'd8,
    ST_TRAILING = 4'd9
  } status_e;

  typedef enum logic [7:0] {
    TYPE_CLIENT_HELLO = 8'd1,
    TYPE_SERVER_HELLO = 8'd2,
    TYPE_DATA         = 8'd3,
    TYPE_CLOSE        = 8'd4
  } msg_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC_WORD       = 3'd0,
    CFG_VERSION_NUMBER   = 3'd1,
    CFG_MAX_INNER_LEN    = 3'd2,
    CFG_TAG_LEN          = 3'd3,
    CFG_CLIENT_HELLO_LEN = 3'd4,
    CFG_SERVER_HELLO_LEN = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       body_encrypted;
  } in_beat_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  msg_type;
    logic [63:0] session_val;
    logic [63:0] sequence_number;
    logic [15:0] payload_len;
  } out_beat_t;

endpackage

// ===== hw/rtl/tunnel_header_parse_check.sv =====
// tunnel header parse and check: byte stream in, one verdict per datagram out
//
// Bytes of a datagram enter on the in channel, one beat each, with last_byte
// on the final one. The 28-byte big-endian header is captured on the fly;
// on the last beat one result beat leaves on the out channel with the status
// (first failing check, or ok) and the captured type, session id, sequence
// and payload length, all zero on a short datagram. Non-last beats give no result.
// A beat is processed straight out of the input register once it is accepted,
// and a last beat's verdict is registered in the output register. Throughput
// is one byte per cycle while no last beat waits for the out slot, set by the
// single compare-and-shift update of the header capture registers.
// A result waiting in the output register does not stop intake of the next
// datagram's bytes; only a second last beat waits until the out slot frees.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i, by the user
// only while the block is idle (the block does not enforce this); unknown indexes
// are ignored. Reset clears the byte counter, the capture state and both valid
// flags and loads the register defaults; the block is ready right after reset.
`include "tunnel_header_parse_check_macros.svh"
module tunnel_header_parse_check import thpc_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_beat_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_beat_t             out_data_o
);

  localparam logic [COUNT_BITS-1:0] Pos4  = COUNT_BITS'(4);
  localparam logic [COUNT_BITS-1:0] Pos5  = COUNT_BITS'(5);
  localparam logic [COUNT_BITS-1:0] Pos8  = COUNT_BITS'(8);
  localparam logic [COUNT_BITS-1:0] Pos16 = COUNT_BITS'(16);
  localparam logic [COUNT_BITS-1:0] Pos24 = COUNT_BITS'(24);
  localparam logic [COUNT_BITS-1:0] Pos26 = COUNT_BITS'(26);
  localparam logic [COUNT_BITS-1:0] HdrLen = COUNT_BITS'(HDR_BYTES);

  // configuration registers
  logic [31:0] magic_q;
  logic [7:0]  version_q;
  logic [15:0] max_inner_q;
  logic [7:0]  tag_len_q;
  logic [15:0] ch_len_q;
  logic [15:0] sh_len_q;

  // input and output stages
  in_beat_t  in_q;
  logic      in_valid_q;
  out_beat_t out_q;
  out_beat_t res_d;
  logic      out_valid_q;
  logic      advance;
  logic      emit;

  // frame state
  logic [COUNT_BITS-1:0] byte_cnt_q, byte_cnt_d, cnt_nxt;
  logic                  magic_bad_q, magic_bad_d, magic_bad_u;
  logic [7:0]            version_seen_q, version_seen_d, version_u;
  logic [7:0]            type_seen_q, type_seen_d, type_u;
  logic                  flags_bad_q, flags_bad_d, flags_bad_u;
  logic [63:0]           session_q, session_d, session_u;
  logic [63:0]           sequence_q, sequence_d, sequence_u;
  logic [15:0]           length_q, length_d, length_u;

  logic [7:0]            magic_want;
  logic [COUNT_BITS-1:0] body_bytes;
  logic [COUNT_BITS-1:0] exp_len;
  logic [16:0]           exp_sum;
  status_e               cmp_status;
  status_e               body_status;
  status_e               status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q     <= MAGIC_WORD_RST;
      version_q   <= VERSION_RST;
      max_inner_q <= MAX_INNER_LEN_RST;
      tag_len_q   <= TAG_LEN_RST;
      ch_len_q    <= CLIENT_HELLO_RST;
      sh_len_q    <= SERVER_HELLO_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAGIC_WORD:       magic_q     <= cfg_data_i[31:0];
        CFG_VERSION_NUMBER:   version_q   <= cfg_data_i[7:0];
        CFG_MAX_INNER_LEN:    max_inner_q <= cfg_data_i[15:0];
        CFG_TAG_LEN:          tag_len_q   <= cfg_data_i[7:0];
        CFG_CLIENT_HELLO_LEN: ch_len_q    <= cfg_data_i[15:0];
        CFG_SERVER_HELLO_LEN: sh_len_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign advance    = in_valid_q && (!in_q.last_byte || !out_valid_q || out_ready_i);
  assign emit       = advance && in_q.last_byte;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // header capture
  always_comb begin
    case (byte_cnt_q[1:0])
      2'd0:    magic_want = magic_q[31:24];
      2'd1:    magic_want = magic_q[23:16];
      2'd2:    magic_want = magic_q[15:8];
      default: magic_want = magic_q[7:0];
    endcase
  end

  always_comb begin
    magic_bad_u = magic_bad_q;
    version_u   = version_seen_q;
    type_u      = type_seen_q;
    flags_bad_u = flags_bad_q;
    session_u   = session_q;
    sequence_u  = sequence_q;
    length_u    = length_q;
    if (byte_cnt_q < Pos4) begin
      magic_bad_u = magic_bad_q || (in_q.data_byte != magic_want);
    end else if (byte_cnt_q == Pos4) begin
      version_u = in_q.data_byte;
    end else if (byte_cnt_q == Pos5) begin
      type_u = in_q.data_byte;
    end else if (byte_cnt_q < Pos8) begin
      flags_bad_u = flags_bad_q || (in_q.data_byte != 8'd0);
    end else if (byte_cnt_q < Pos16) begin
      session_u = {session_q[55:0], in_q.data_byte};
    end else if (byte_cnt_q < Pos24) begin
      sequence_u = {sequence_q[55:0], in_q.data_byte};
    end else if (byte_cnt_q < Pos26) begin
      length_u = {length_q[7:0], in_q.data_byte};
    end else if (byte_cnt_q < HdrLen) begin
      flags_bad_u = flags_bad_q || (in_q.data_byte != 8'd0);
    end
    cnt_nxt = (&byte_cnt_q) ? byte_cnt_q : byte_cnt_q + COUNT_BITS'(1);
  end

  // verdict
  always_comb begin
    body_bytes = cnt_nxt - HdrLen;
    exp_sum    = {1'b0, length_u};
    if (type_u == TYPE_DATA && in_q.body_encrypted) begin
      exp_sum = {1'b0, length_u} + {9'd0, tag_len_q};
    end
    exp_len = COUNT_BITS'(exp_sum);
    if (body_bytes < exp_len) begin
      cmp_status = ST_LEN;
    end else if (body_bytes > exp_len) begin
      cmp_status = ST_TRAILING;
    end else begin
      cmp_status = ST_OK;
    end
    case (type_u)
      TYPE_DATA: begin
        if (length_u == 16'd0) begin
          body_status = ST_ZERO;
        end else if (length_u > max_inner_q) begin
          body_status = ST_OVERSIZE;
        end else begin
          body_status = cmp_status;
        end
      end
      TYPE_CLIENT_HELLO: body_status = (length_u != ch_len_q) ? ST_LEN : cmp_status;
      TYPE_SERVER_HELLO: body_status = (length_u != sh_len_q) ? ST_LEN : cmp_status;
      TYPE_CLOSE:        body_status = cmp_status;
      default:           body_status = ST_TYPE;
    endcase
    if (cnt_nxt < HdrLen) begin
      status = ST_SHORT;
    end else if (magic_bad_u) begin
      status = ST_MAGIC;
    end else if (version_u != version_q) begin
      status = ST_VERSION;
    end else if (!(type_u inside {[TYPE_CLIENT_HELLO:TYPE_CLOSE]})) begin
      status = ST_TYPE;
    end else if (flags_bad_u) begin
      status = ST_HEADER;
    end else begin
      status = body_status;
    end
    res_d.status = status;
    if (status == ST_SHORT) begin
      res_d.msg_type        = 8'd0;
      res_d.session_val     = 64'd0;
      res_d.sequence_number = 64'd0;
      res_d.payload_len     = 16'd0;
    end else begin
      res_d.msg_type        = type_u;
      res_d.session_val     = session_u;
      res_d.sequence_number = sequence_u;
      res_d.payload_len     = length_u;
    end
  end

  // next frame state: clear after the last beat
  always_comb begin
    byte_cnt_d     = byte_cnt_q;
    magic_bad_d    = magic_bad_q;
    version_seen_d = version_seen_q;
    type_seen_d    = type_seen_q;
    flags_bad_d    = flags_bad_q;
    session_d      = session_q;
    sequence_d     = sequence_q;
    length_d       = length_q;
    if (advance) begin
      if (in_q.last_byte) begin
        byte_cnt_d     = '0;
        magic_bad_d    = 1'b0;
        version_seen_d = 8'd0;
        type_seen_d    = 8'd0;
        flags_bad_d    = 1'b0;
        session_d      = 64'd0;
        sequence_d     = 64'd0;
        length_d       = 16'd0;
      end else begin
        byte_cnt_d     = cnt_nxt;
        magic_bad_d    = magic_bad_u;
        version_seen_d = version_u;
        type_seen_d    = type_u;
        flags_bad_d    = flags_bad_u;
        session_d      = session_u;
        sequence_d     = sequence_u;
        length_d       = length_u;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q     <= '0;
      magic_bad_q    <= 1'b0;
      version_seen_q <= 8'd0;
      type_seen_q    <= 8'd0;
      flags_bad_q    <= 1'b0;
      session_q      <= 64'd0;
      sequence_q     <= 64'd0;
      length_q       <= 16'd0;
    end else begin
      byte_cnt_q     <= byte_cnt_d;
      magic_bad_q    <= magic_bad_d;
      version_seen_q <= version_seen_d;
      type_seen_q    <= type_seen_d;
      flags_bad_q    <= flags_bad_d;
      session_q      <= session_d;
      sequence_q     <= sequence_d;
      length_q       <= length_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `THPC_ASSERT(a_result_from_last, $rose(out_valid_q) |-> $past(emit), "result without last beat")
  `THPC_ASSERT(a_count_cleared, emit |=> byte_cnt_q == '0, "byte count not cleared after result")
  `THPC_ASSERT(a_short_zero, out_valid_q && out_q.status == ST_SHORT |-> out_q.session_val == 64'd0 && out_q.sequence_number == 64'd0 && out_q.payload_len == 16'd0, "short result carries fields")
  `THPC_ASSERT_NEVER(a_stall_cause, !in_ready_o && !(in_valid_q && out_valid_q && in_q.last_byte), "input stalled without a blocked last beat")

endmodule
